// ----- hw/rtl/pqtf_pkg.sv -----
// Shared constants, word types and control types for the quintic table block.
package pqtf_pkg;

  localparam int TABLE_ROWS    = 256;
  localparam int MAX_COLUMNS   = 64;
  localparam int MAX_NEIGHBORS = 1024;
  localparam int POWERS        = 6;
  localparam int ROW_IDX_W     = $clog2(TABLE_ROWS);
  localparam int COL_W         = $clog2(MAX_COLUMNS);
  localparam int STORE_ROWS    = TABLE_ROWS * MAX_COLUMNS;
  localparam int ADDR_W        = ROW_IDX_W + COL_W;
  localparam int PWR_W         = 3;
  localparam int NBR_W         = 11;
  localparam int LW_W          = 7;
  localparam int DIV_N         = 33;
  localparam int DIV_D         = 31;
  localparam int DIV_CNT_W     = $clog2(DIV_N + 1);
  localparam int IDX_SUM_W     = DIV_N + 2;

  localparam logic CMD_TABLE    = 1'b0;
  localparam logic CMD_NEIGHBOR = 1'b1;

  typedef enum logic [2:0] {
    CFG_LOWER,
    CFG_SPLIT,
    CFG_UPPER,
    CFG_FINE,
    CFG_COARSE,
    CFG_NCOUNT,
    CFG_LWIDTH
  } cfg_idx_t;

  typedef struct packed {
    logic               cmd;
    logic [7:0]         table_row;
    logic [5:0]         table_column;
    logic [2:0]         table_power;
    logic signed [31:0] coefficient;
    logic signed [31:0] x_value;
    logic signed [31:0] pad_x;
    logic signed [31:0] weight0;
    logic signed [31:0] weight1;
    logic signed [31:0] weight2;
    logic signed [31:0] weight3;
  } in_word_t;

  typedef struct packed {
    logic [5:0]         column;
    logic signed [63:0] sum0;
    logic signed [63:0] sum1;
    logic signed [63:0] sum2;
    logic signed [63:0] sum3;
    logic               last_column;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV1,
    S_DIV2,
    S_RD,
    S_H0,
    S_MUL,
    S_ADD,
    S_W,
    S_S,
    S_A,
    S_E_RD,
    S_E_LD
  } state_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic write_coef;
    logic skip_adv;
    logic div_start;
    logic div_sel;
    logic take_q1;
    logic take_loc;
    logic rd_issue;
    logic h_load;
    logic h_mul;
    logic h_add;
    logic w_mul;
    logic s_mul;
    logic acc_write;
    logic col_inc;
    logic col_clr;
    logic out_load;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cmd_bit;
    logic skip;
    logic ends;
    logic div_done;
    logic h_last;
    logic col_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hw/rtl/pqtf_div.sv -----
// Restoring divider, one quotient bit per cycle.
module pqtf_div
  import pqtf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_N-1:0] dividend,
  input  logic [DIV_D-1:0] divisor,
  output logic             done,
  output logic [DIV_N-1:0] quot,
  output logic [DIV_D-1:0] rem
);

  logic [DIV_N-1:0]     q_r, q_nxt;
  logic [DIV_D-1:0]     rem_r, rem_nxt;
  logic [DIV_D-1:0]     d_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [DIV_D:0]       shifted;
  logic [DIV_D:0]       diff;

  always_comb begin
    shifted = {rem_r, q_r[DIV_N-1]};
    diff    = shifted - {1'b0, d_r};
    if (shifted >= {1'b0, d_r}) begin
      rem_nxt = diff[DIV_D-1:0];
      q_nxt   = {q_r[DIV_N-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DIV_D-1:0];
      q_nxt   = {q_r[DIV_N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_N);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

// ----- hw/rtl/pqtf_ctrl.sv -----
// Sequencer for table writes, skipped words, interval search, column evaluation and emit.
module pqtf_ctrl
  import pqtf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd,
  output logic      in_stall,
  output state_t    state
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (stat.cmd_bit == CMD_TABLE) begin
          cmd.write_coef = 1'b1;
          state_nxt      = S_IDLE;
        end else if (stat.skip) begin
          cmd.skip_adv = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV1;
        end
      end
      S_DIV1: begin
        if (stat.div_done) begin
          cmd.take_q1   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_nxt     = S_DIV2;
        end
      end
      S_DIV2: begin
        if (stat.div_done) begin
          cmd.take_loc = 1'b1;
          cmd.col_clr  = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_H0;
      end
      S_H0: begin
        cmd.h_load = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.h_mul = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.h_add = 1'b1;
        state_nxt = stat.h_last ? S_W : S_MUL;
      end
      S_W: begin
        cmd.w_mul = 1'b1;
        state_nxt = S_S;
      end
      S_S: begin
        cmd.s_mul = 1'b1;
        state_nxt = S_A;
      end
      S_A: begin
        cmd.acc_write = 1'b1;
        if (!stat.col_last) begin
          cmd.col_inc = 1'b1;
          state_nxt   = S_RD;
        end else if (stat.ends) begin
          cmd.col_clr = 1'b1;
          state_nxt   = S_E_RD;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_E_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_E_LD;
      end
      S_E_LD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.col_last) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            cmd.col_inc = 1'b1;
            state_nxt   = S_E_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
  assign state    = state_r;

endmodule

// ----- hw/rtl/pqtf_dp.sv -----
// Datapath: config registers, coefficient store, interval search, Horner and sums.
module pqtf_dp
  import pqtf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  in_word_t    in_word,
  input  ctrl_cmd_t   cmd,
  output dp_stat_t    stat,
  input  logic        out_stall,
  output logic        out_valid,
  output out_word_t   out_word
);

  // configuration
  logic signed [31:0] lower_r, split_r, upper_r;
  logic [30:0]        fine_r, coarse_r;
  logic [NBR_W-1:0]   ncount_r;
  logic [LW_W-1:0]    lwidth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r  <= 32'sd0;
      split_r  <= 32'sd16777216;
      upper_r  <= 32'sd33554432;
      fine_r   <= 31'd65536;
      coarse_r <= 31'd655360;
      ncount_r <= NBR_W'(1);
      lwidth_r <= LW_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LOWER:  lower_r  <= cfg_wdata;
        CFG_SPLIT:  split_r  <= cfg_wdata;
        CFG_UPPER:  upper_r  <= cfg_wdata;
        CFG_FINE:   fine_r   <= cfg_wdata[30:0];
        CFG_COARSE: coarse_r <= cfg_wdata[30:0];
        CFG_NCOUNT: ncount_r <= cfg_wdata[NBR_W-1:0];
        CFG_LWIDTH: lwidth_r <= cfg_wdata[LW_W-1:0];
        default: ;
      endcase
    end
  end

  logic [NBR_W-1:0] ncnt;
  logic [LW_W-1:0]  width;
  logic [30:0]      fs, cs;

  always_comb begin
    if (ncount_r == '0) ncnt = NBR_W'(1);
    else if (32'(ncount_r) > 32'(MAX_NEIGHBORS)) ncnt = NBR_W'(MAX_NEIGHBORS);
    else ncnt = ncount_r;
    if (lwidth_r == '0) width = LW_W'(1);
    else if (32'(lwidth_r) > 32'(MAX_COLUMNS)) width = LW_W'(MAX_COLUMNS);
    else width = lwidth_r;
    fs = (fine_r == '0) ? 31'd1 : fine_r;
    cs = (coarse_r == '0) ? 31'd1 : coarse_r;
  end

  // captured word and atom state
  in_word_t         in_r;
  logic [NBR_W-1:0] nidx_r;
  logic             skip_r;
  logic             ends_r, last_r;
  logic [NBR_W-1:0] scale_r;
  logic             last_item, ends_now;
  logic [NBR_W-1:0] scale_now;

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_word;
  end

  always_comb begin
    last_item = ({1'b0, nidx_r} + 1'b1) >= {1'b0, ncnt};
    ends_now  = last_item || (in_r.x_value == in_r.pad_x);
    scale_now = (ends_now && nidx_r < ncnt) ? (ncnt - nidx_r) : NBR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      ends_r  <= ends_now;
      last_r  <= last_item;
      scale_r <= scale_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nidx_r <= '0;
      skip_r <= 1'b0;
    end else if (cmd.skip_adv) begin
      if (last_item) begin
        nidx_r <= '0;
        skip_r <= 1'b0;
      end else begin
        nidx_r <= nidx_r + 1'b1;
      end
    end else if (cmd.finish) begin
      if (ends_r && last_r) begin
        nidx_r <= '0;
      end else begin
        nidx_r <= nidx_r + 1'b1;
        if (ends_r) skip_r <= 1'b1;
      end
    end
  end

  // interval search
  logic signed [31:0] x;
  logic               below, fine, coarse;
  logic [DIV_N-1:0]   n1, n2, dvd;
  logic [DIV_D-1:0]   dvs;
  logic               div_done;
  logic [DIV_N-1:0]   quot, q1_r;
  logic [DIV_D-1:0]   rem, r1_r;

  assign x = in_r.x_value;

  always_comb begin
    below  = x < lower_r;
    fine   = !below && (x < split_r);
    coarse = !below && !fine && (x < upper_r);
    if (fine) n1 = DIV_N'(33'({x[31], x}) - 33'({lower_r[31], lower_r}));
    else if (split_r > lower_r)
      n1 = DIV_N'(33'({split_r[31], split_r}) - 33'({lower_r[31], lower_r}));
    else n1 = '0;
    if (coarse) n2 = DIV_N'(33'({x[31], x}) - 33'({split_r[31], split_r}));
    else if (upper_r > split_r)
      n2 = DIV_N'(33'({upper_r[31], upper_r}) - 33'({split_r[31], split_r}));
    else n2 = '0;
    dvd = cmd.div_sel ? n2 : n1;
    dvs = cmd.div_sel ? cs : fs;
  end

  pqtf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_q1) begin
      q1_r <= quot;
      r1_r <= rem;
    end
  end

  logic signed [IDX_SUM_W-1:0] isum;
  logic [30:0]                 off_nxt, off_r;
  logic [ROW_IDX_W-1:0]        idx_nxt, idx_r;

  always_comb begin
    if (below) begin
      isum    = '0;
      off_nxt = '0;
    end else if (fine) begin
      isum    = $signed(IDX_SUM_W'(q1_r));
      off_nxt = r1_r;
    end else if (coarse) begin
      isum    = $signed(IDX_SUM_W'(q1_r) + IDX_SUM_W'(quot));
      off_nxt = rem;
    end else begin
      isum    = $signed(IDX_SUM_W'(q1_r) + IDX_SUM_W'(quot) - IDX_SUM_W'(1));
      off_nxt = '0;
    end
    if (isum < 0) idx_nxt = '0;
    else if (isum > IDX_SUM_W'(TABLE_ROWS - 1)) idx_nxt = ROW_IDX_W'(TABLE_ROWS - 1);
    else idx_nxt = isum[ROW_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_loc) begin
      idx_r <= idx_nxt;
      off_r <= off_nxt;
    end
  end

  // column counter
  logic [COL_W-1:0] col_r;
  logic             col_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (cmd.col_clr) begin
      col_r <= '0;
    end else if (cmd.col_inc) begin
      col_r <= col_r + 1'b1;
    end
  end

  assign col_last = (LW_W'(col_r) == width - 1'b1);

  // coefficient store, one bank per power
  logic [31:0]       coef_mem [POWERS][STORE_ROWS];
  logic signed [31:0] a_r [POWERS];
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic              coef_we;

  assign wr_addr = {in_r.table_row[ROW_IDX_W-1:0], in_r.table_column[COL_W-1:0]};
  assign rd_addr = {idx_r, col_r};
  assign coef_we = cmd.write_coef
                && (32'(in_r.table_row) < 32'(TABLE_ROWS))
                && (32'(in_r.table_column) < 32'(MAX_COLUMNS))
                && (32'(in_r.table_power) < 32'(POWERS));

  for (genvar p = 0; p < POWERS; p++) begin : g_bank
    always_ff @(posedge clk) begin
      if (coef_we && (32'(in_r.table_power) == p)) coef_mem[p][wr_addr] <= in_r.coefficient;
      if (cmd.rd_issue) a_r[p] <= coef_mem[p][rd_addr];
    end
  end

  // Horner evaluation
  logic signed [31:0] h_r;
  logic signed [63:0] prod_r, prod;
  logic [PWR_W-1:0]   hp_r;
  logic signed [40:0] hsum;
  logic signed [31:0] hsat;

  always_comb begin
    prod = h_r * $signed({1'b0, off_r});
    hsum = 41'(prod_r >>> 24) + 41'(a_r[hp_r]);
    if (hsum > 41'sd2147483647) hsat = 32'sh7FFFFFFF;
    else if (hsum < -41'sd2147483648) hsat = 32'sh80000000;
    else hsat = hsum[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.h_load) begin
      h_r  <= a_r[POWERS-1];
      hp_r <= PWR_W'(POWERS - 2);
    end else if (cmd.h_add) begin
      h_r  <= hsat;
      hp_r <= hp_r - 1'b1;
    end
    if (cmd.h_mul) prod_r <= prod;
  end

  // weight products, scale and accumulation
  logic signed [31:0] w [4];
  logic signed [63:0] pw_r [4];
  logic signed [63:0] ps_r [4];
  logic signed [75:0] sm [4];
  logic signed [63:0] ps_nxt [4];
  logic signed [63:0] old [4];
  logic signed [64:0] asum [4];
  logic [255:0]       acc_new;

  assign w[0] = in_r.weight0;
  assign w[1] = in_r.weight1;
  assign w[2] = in_r.weight2;
  assign w[3] = in_r.weight3;

  logic [255:0]           acc_mem [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] acc_vld_r;
  logic [255:0]           acc_rd_r;
  logic                   vld_rd_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sm[k] = pw_r[k] * $signed({1'b0, scale_r});
      if (sm[k] > 76'sh7FFF_FFFF_FFFF_FFFF) ps_nxt[k] = 64'sh7FFFFFFFFFFFFFFF;
      else if (sm[k] < -76'sh8000_0000_0000_0000) ps_nxt[k] = 64'sh8000000000000000;
      else ps_nxt[k] = sm[k][63:0];
      old[k]  = vld_rd_r ? $signed(acc_rd_r[k*64 +: 64]) : 64'sd0;
      asum[k] = 65'(old[k]) + 65'(ps_r[k]);
      if (asum[k] > 65'sh7FFF_FFFF_FFFF_FFFF) acc_new[k*64 +: 64] = 64'h7FFFFFFFFFFFFFFF;
      else if (asum[k] < -65'sh8000_0000_0000_0000)
        acc_new[k*64 +: 64] = 64'h8000000000000000;
      else acc_new[k*64 +: 64] = asum[k][63:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (cmd.w_mul) pw_r[k] <= h_r * w[k];
      if (cmd.s_mul) ps_r[k] <= ps_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_write) acc_mem[col_r] <= acc_new;
    if (cmd.rd_issue) acc_rd_r <= acc_mem[col_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
      vld_rd_r  <= 1'b0;
    end else begin
      if (cmd.rd_issue) vld_rd_r <= acc_vld_r[col_r];
      if (cmd.finish && ends_r) acc_vld_r <= '0;
      else if (cmd.acc_write) acc_vld_r[col_r] <= 1'b1;
    end
  end

  // output register
  logic      out_valid_r;
  out_word_t out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r.column      <= 6'(col_r);
      out_word_r.sum0        <= vld_rd_r ? $signed(acc_rd_r[63:0])    : 64'sd0;
      out_word_r.sum1        <= vld_rd_r ? $signed(acc_rd_r[127:64])  : 64'sd0;
      out_word_r.sum2        <= vld_rd_r ? $signed(acc_rd_r[191:128]) : 64'sd0;
      out_word_r.sum3        <= vld_rd_r ? $signed(acc_rd_r[255:192]) : 64'sd0;
      out_word_r.last_column <= col_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    stat.cmd_bit  = in_r.cmd;
    stat.skip     = skip_r;
    stat.ends     = ends_r;
    stat.div_done = div_done;
    stat.h_last   = (hp_r == '0);
    stat.col_last = col_last;
    stat.out_free = !out_valid_r || !out_stall;
  end

endmodule

// ----- hw/rtl/piecewise_quintic_table_fusion_top.sv -----
// A table write or skipped word is decoded, then the block is idle; a neighbor word
// runs two divisions, per-column Horner, and at atom end an emit held by out_stall.
// Throughput: one word at a time; the two interval divisions and the
// per-column Horner/multiply-accumulate sequence set the figure.
// Reset (rst_n low, synchronous): config to defaults, sums cleared, atom count zero;
// the coefficient store keeps its contents and needs no clearing pass.
module piecewise_quintic_table_fusion_top
  import pqtf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  state_t    state;

  pqtf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall),
    .state    (state)
  );

  pqtf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  a_div_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state == S_DIV1 || state == S_DIV2))
    else $error("divider finished outside interval search");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("output word lost on load");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (state == S_IDLE && !in_stall))
    else $error("block not idle after finishing a word");

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the quintic table block: queued driver, monitor, predictor and scoreboard.
`timescale 1ns / 1ps
module tb;
  import pqtf_pkg::*;

  localparam int LIMIT = 20000;
  localparam int SETTLE = 1500;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  piecewise_quintic_table_fusion_top u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_word_t pending_words[$];
  out_word_t expected_columns[$];
  int errors = 0;
  bit calm = 1'b0;

  longint lower_q, split_q, upper_q, fine_q, coarse_q;
  int unsigned count_reg, width_reg;
  logic [31:0] coef_mem [0:STORE_ROWS*POWERS-1];
  longint sums [0:MAX_COLUMNS*4-1];
  int unsigned nbr_pos;
  bit skipping;
  int filled_cols [0:TABLE_ROWS-1];

  function automatic int unsigned eff_count();
    int unsigned c;
    c = (count_reg == 0) ? 1 : count_reg;
    return (c > MAX_NEIGHBORS) ? MAX_NEIGHBORS : c;
  endfunction

  function automatic int unsigned eff_width();
    int unsigned c;
    c = (width_reg == 0) ? 1 : width_reg;
    return (c > MAX_COLUMNS) ? MAX_COLUMNS : c;
  endfunction

  function automatic void locate_interval(input longint x, output longint idx,
                                          output longint off);
    longint fs, cs, first, second;
    fs = (fine_q == 0) ? 1 : fine_q;
    cs = (coarse_q == 0) ? 1 : coarse_q;
    first = (split_q > lower_q) ? (split_q - lower_q) / fs : 0;
    if (x < lower_q) begin
      idx = 0; off = 0;
    end else if (x < split_q) begin
      idx = (x - lower_q) / fs; off = (x - lower_q) % fs;
    end else if (x < upper_q) begin
      idx = first + (x - split_q) / cs; off = (x - split_q) % cs;
    end else begin
      second = (upper_q > split_q) ? (upper_q - split_q) / cs : 0;
      idx = first + second - 1; off = 0;
    end
    if (idx < 0) idx = 0;
    if (idx > TABLE_ROWS - 1) idx = TABLE_ROWS - 1;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint scaled_add(longint acc, longint term, longint scale);
    logic signed [127:0] a, b, prod;
    logic signed [64:0] s, c, t;
    longint p;
    a = term; b = scale; prod = a * b;
    if (prod > 128'sh7FFFFFFFFFFFFFFF) p = 64'sh7FFFFFFFFFFFFFFF;
    else if (prod < -128'sh8000000000000000) p = 64'sh8000000000000000;
    else p = prod[63:0];
    c = acc; t = p; s = c + t;
    if (s > 65'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFFFFFFFFFFFFFF;
    if (s < -65'sh8000_0000_0000_0000) return 64'sh8000000000000000;
    return s[63:0];
  endfunction

  function automatic void predict_word(in_word_t w);
    int unsigned cnt, wid, base;
    bit last_item, ends;
    longint x, idx, off, scale, h, t;
    longint wt [4];
    out_word_t r;
    if (w.cmd == CMD_TABLE) begin
      if (w.table_power < POWERS)
        coef_mem[(int'(w.table_row) * MAX_COLUMNS + int'(w.table_column)) * POWERS
                 + int'(w.table_power)] = w.coefficient;
      return;
    end
    cnt = eff_count();
    wid = eff_width();
    last_item = (nbr_pos + 1 >= cnt);
    if (skipping) begin
      if (last_item) begin
        nbr_pos = 0; skipping = 1'b0;
      end else begin
        nbr_pos++;
      end
      return;
    end
    x = w.x_value;
    ends = last_item || (w.x_value == w.pad_x);
    scale = (ends && nbr_pos < cnt) ? longint'(cnt - nbr_pos) : 1;
    wt[0] = w.weight0; wt[1] = w.weight1; wt[2] = w.weight2; wt[3] = w.weight3;
    locate_interval(x, idx, off);
    for (int c = 0; c < wid; c++) begin
      base = (int'(idx) * MAX_COLUMNS + c) * POWERS;
      h = longint'($signed(coef_mem[base + 5]));
      for (int p = 4; p >= 0; p--) begin
        t = h * off;
        h = clamp32(longint'($signed(coef_mem[base + p])) + (t >>> 24));
      end
      for (int k = 0; k < 4; k++)
        sums[c*4 + k] = scaled_add(sums[c*4 + k], h * wt[k], scale);
    end
    if (!ends) begin
      nbr_pos++;
      return;
    end
    for (int c = 0; c < wid; c++) begin
      r.column = 6'(c);
      r.sum0 = sums[c*4]; r.sum1 = sums[c*4 + 1];
      r.sum2 = sums[c*4 + 2]; r.sum3 = sums[c*4 + 3];
      r.last_column = (c + 1 == wid);
      expected_columns.push_back(r);
    end
    foreach (sums[i]) sums[i] = 0;
    if (last_item) begin
      nbr_pos = 0;
    end else begin
      nbr_pos++; skipping = 1'b1;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", field, got, want);
    errors++;
  endtask

  int in_gap = 0;
  int out_gap = 0;
  int quiet = 0;
  bit in_take, out_take;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      in_take = in_valid && !in_stall;
      if (in_take) predict_word(in_word);
      if (!in_valid || in_take) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_take = out_valid && !out_stall;
      if (out_take) begin
        if (expected_columns.size() == 0) begin
          report("unexpected column", longint'(out_word.column), -1);
        end else begin
          out_word_t e;
          e = expected_columns.pop_front();
          if (out_word.column != e.column) report("column", out_word.column, e.column);
          if (out_word.sum0 != e.sum0) report("sum0", out_word.sum0, e.sum0);
          if (out_word.sum1 != e.sum1) report("sum1", out_word.sum1, e.sum1);
          if (out_word.sum2 != e.sum2) report("sum2", out_word.sum2, e.sum2);
          if (out_word.sum3 != e.sum3) report("sum3", out_word.sum3, e.sum3);
          if (out_word.last_column != e.last_column)
            report("last_column", out_word.last_column, e.last_column);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_gap = pick_gap();
        out_stall <= (out_gap > 0);
      end
      if ((in_valid && !in_stall) || out_take || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    @(posedge clk);
    while (pending_words.size() > 0 || in_valid || expected_columns.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_LOWER:  lower_q = longint'($signed(v));
      CFG_SPLIT:  split_q = longint'($signed(v));
      CFG_UPPER:  upper_q = longint'($signed(v));
      CFG_FINE:   fine_q = longint'(v[30:0]);
      CFG_COARSE: coarse_q = longint'(v[30:0]);
      CFG_NCOUNT: count_reg = v[10:0];
      CFG_LWIDTH: width_reg = v[6:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(logic [31:0] lb, logic [31:0] sp, logic [31:0] ul,
                       logic [31:0] fs, logic [31:0] cs, logic [31:0] nc,
                       logic [31:0] lw);
    wait_idle();
    cfg_write(CFG_LOWER, lb);
    cfg_write(CFG_SPLIT, sp);
    cfg_write(CFG_UPPER, ul);
    cfg_write(CFG_FINE, fs);
    cfg_write(CFG_COARSE, cs);
    cfg_write(CFG_NCOUNT, nc);
    cfg_write(CFG_LWIDTH, lw);
    calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic push_table(logic [7:0] row, logic [5:0] col, logic [2:0] pw,
                            logic [31:0] v);
    in_word_t w;
    w = '0;
    w.cmd = CMD_TABLE;
    w.table_row = row; w.table_column = col; w.table_power = pw; w.coefficient = v;
    w.x_value = $urandom; w.pad_x = $urandom;
    w.weight0 = $urandom; w.weight1 = $urandom; w.weight2 = $urandom; w.weight3 = $urandom;
    pending_words.push_back(w);
  endtask

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h01FFFFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_neighbor(logic [31:0] x, logic [31:0] pad);
    in_word_t w;
    longint idx, off;
    locate_interval(longint'($signed(x)), idx, off);
    for (int c = filled_cols[idx]; c < eff_width(); c++)
      for (int p = 0; p < POWERS; p++)
        push_table(8'(idx), 6'(c), 3'(p),
                   (p == 0) ? $urandom : $urandom_range(0, 32'h03FFFFFF)
                   ^ {32{$urandom_range(0, 1) == 1'b1}});
    if (filled_cols[idx] < eff_width()) filled_cols[idx] = eff_width();
    w.cmd = CMD_NEIGHBOR;
    w.table_row = $urandom; w.table_column = $urandom; w.table_power = $urandom;
    w.coefficient = $urandom;
    w.x_value = x; w.pad_x = pad;
    w.weight0 = pick_weight(); w.weight1 = pick_weight();
    w.weight2 = pick_weight(); w.weight3 = pick_weight();
    pending_words.push_back(w);
  endtask

  function automatic logic [31:0] pick_x();
    longint span, stp;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return lower_q[31:0];
      2: return split_q[31:0];
      3: return upper_q[31:0];
      4: begin
        span = (split_q > lower_q) ? split_q - lower_q : 1;
        stp = (fine_q == 0) ? 1 : fine_q;
        if (span > stp) span = stp;
        return 32'(lower_q + longint'($urandom_range(0, 32'(span - 1))));
      end
      default: begin
        span = (upper_q > split_q) ? upper_q - split_q : 1;
        stp = (coarse_q == 0) ? 1 : coarse_q;
        if (span > stp) span = stp;
        return 32'(split_q + longint'($urandom_range(0, 32'(span - 1))));
      end
    endcase
  endfunction

  task automatic random_items(int n);
    int pos, stop;
    logic [31:0] x;
    pos = 0;
    stop = $urandom_range(0, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        push_table($urandom, $urandom, $urandom, $urandom);
      end else begin
        x = pick_x();
        push_neighbor(x, (pos == stop) ? x : $urandom);
        pos++;
        if (pos >= eff_count() || $urandom_range(0, 19) == 0) begin
          pos = 0;
          stop = $urandom_range(0, 8);
        end
      end
    end
  endtask

  initial begin
    lower_q = 0; split_q = 32'h01000000; upper_q = 32'h02000000;
    fine_q = 32'h00010000; coarse_q = 32'h000A0000;
    count_reg = 1; width_reg = 64;
    nbr_pos = 0; skipping = 1'b0;
    foreach (sums[i]) sums[i] = 0;
    foreach (filled_cols[i]) filled_cols[i] = 0;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    setup(32'h0, 32'h01000000, 32'h02000000, 32'h00010000, 32'h000A0000, 32'd1, 32'd2);
    push_table(8'd0, 6'd0, 3'd5, 32'h7FFFFFFF);
    push_table(8'd0, 6'd1, 3'd5, 32'h80000000);
    push_table(8'd0, 6'd0, 3'd6, 32'h12345678);
    push_table(8'd255, 6'd63, 3'd7, 32'hFFFFFFFF);
    push_neighbor(32'h80000000, 32'h0);
    push_neighbor(32'h00000000, 32'h00000000);
    push_neighbor(32'h00800000, 32'h1);
    push_neighbor(32'h01000000, 32'h2);
    push_neighbor(32'h01800000, 32'h3);
    push_neighbor(32'h02000000, 32'h4);
    push_neighbor(32'h7FFFFFFF, 32'h7FFFFFFF);
    push_table(8'd0, 6'd0, 3'd0, 32'h7FFFFFFF);
    push_table(8'd0, 6'd0, 3'd5, 32'h80000000);
    push_neighbor(32'hFFFFFFFF, 32'h0);
    push_neighbor(32'h00FFFFFF, 32'h0);

    setup(32'h0, 32'h01000000, 32'h02000000, 32'h00010000, 32'h000A0000, 32'd4, 32'd3);
    random_items(25);
    setup(32'h80000000, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000001, 32'd3, 32'd1);
    random_items(15);
    setup(32'd100, 32'd50, 32'd20, 32'h80000000, 32'h0, 32'd0, 32'd0);
    random_items(10);
    setup(32'h0, 32'h01000000, 32'h02000000, 32'h00010000, 32'h000A0000, 32'd1024, 32'd5);
    for (int i = 0; i < 12; i++) push_neighbor(32'h00000100, (i == 2) ? 32'h00000100 : 32'h1);
    setup(32'h0, 32'h01000000, 32'h02000000, 32'h00010000, 32'h000A0000, 32'd3, 32'd4);
    random_items(10);
    setup(32'h0, 32'h01000000, 32'h02000000, 32'h00010000, 32'h000A0000, 32'd2, 32'd5);
    for (int i = 0; i < 6; i++) push_neighbor((i % 2) ? 32'h7FFFFFFF : 32'h80000000, $urandom);
    setup($urandom, $urandom, $urandom, $urandom, $urandom, 32'd2047, 32'd2);
    random_items(12);
    setup(32'hFF000000 | $urandom_range(0, 32'hFFFF), $urandom_range(0, 32'h00FFFFFF),
          32'h01000000 + $urandom_range(0, 32'h00FFFFFF), $urandom_range(1, 32'h00100000),
          $urandom_range(1, 32'h00400000), 32'd5, 32'd3);
    random_items(25);
    setup(32'h0, 32'h01000000, 32'h02000000, 32'h00010000, 32'h000A0000, 32'd6, 32'd2);
    random_items(30);

    wait_idle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/pqtf_pkg.sv
hw/rtl/pqtf_div.sv
hw/rtl/pqtf_ctrl.sv
hw/rtl/pqtf_dp.sv
hw/rtl/piecewise_quintic_table_fusion_top.sv
tb/sv/tb.sv
